// ===== hdl/bit_manipulation_unit_64_defines.svh =====
// Assertion macros for the bit manipulation unit.
// Used by the top level; expects clk and rst in the scope of use.
`ifndef BIT_MANIPULATION_UNIT_64_DEFINES_SVH
`define BIT_MANIPULATION_UNIT_64_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define BMU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmu assertion failed");

// Antecedent implies a delayed consequent, for latency checks.
`define BMU_ASSERT_LAT2(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("bmu latency assertion failed");

`endif

// ===== hdl/bmu_pkg.sv =====
// Shared types and constants for the bit manipulation unit.
// No dependencies.
package bmu_pkg;

  localparam int DATA_W = 64;
  localparam int AMT_W  = 6;
  localparam int OP_W   = 4;
  localparam int CNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_SHR     = 4'd0,
    OP_HIGHBIT = 4'd1,
    OP_LOWBIT  = 4'd2,
    OP_POPCNT  = 4'd3,
    OP_CLZ     = 4'd4,
    OP_CTZ     = 4'd5,
    OP_ROTL    = 4'd6,
    OP_ROTR    = 4'd7,
    OP_BSWAP   = 4'd8,
    OP_BITREV  = 4'd9,
    OP_SIGNUM  = 4'd10
  } op_t;

endpackage

// ===== hdl/bmu_popcnt.sv =====
// Population count of a 64-bit word as a binary adder tree.
// Depends on bmu_pkg.
module bmu_popcnt (
  input  logic [bmu_pkg::DATA_W-1:0] value,
  output logic [bmu_pkg::CNT_W-1:0]  count
);

  logic [1:0] l1 [32];
  logic [2:0] l2 [16];
  logic [3:0] l3 [8];
  logic [4:0] l4 [4];
  logic [5:0] l5 [2];

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      l1[i] = {1'b0, value[2*i]} + {1'b0, value[2*i+1]};
    end
    for (int i = 0; i < 16; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
    end
    count = {1'b0, l5[0]} + {1'b0, l5[1]};
  end

endmodule

// ===== hdl/bmu_alu.sv =====
// Combinational operation datapath: shifts, rotates, reversals, bit isolation,
// counts and signum. Depends on bmu_pkg and bmu_popcnt.
module bmu_alu (
  input  bmu_pkg::op_t                op,
  input  logic [bmu_pkg::DATA_W-1:0]  x,
  input  logic [bmu_pkg::AMT_W-1:0]   amt,
  output logic [bmu_pkg::DATA_W-1:0]  res
);

  localparam int W = bmu_pkg::DATA_W;

  logic [W-1:0]   smear;
  logic [W-1:0]   pop_src;
  logic [bmu_pkg::CNT_W-1:0] pop_cnt;
  logic [2*W-1:0] rot_l;
  logic [2*W-1:0] rot_r;
  logic [W-1:0]   bswap;
  logic [W-1:0]   brev;

  // smear the highest set bit down to bit 0
  always_comb begin
    smear = x;
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
    smear = smear | (smear >> 32);
  end

  // one popcount shared by popcount, clz and ctz
  always_comb begin
    case (op)
      bmu_pkg::OP_CLZ: pop_src = ~smear;
      bmu_pkg::OP_CTZ: pop_src = ~x & (x - W'(1));
      default:         pop_src = x;
    endcase
  end

  bmu_popcnt u_popcnt (
    .value (pop_src),
    .count (pop_cnt)
  );

  assign rot_l = {x, x} << amt;
  assign rot_r = {x, x} >> amt;

  always_comb begin
    for (int i = 0; i < W / 8; i++) begin
      bswap[8*i +: 8] = x[W-8-8*i +: 8];
    end
    for (int i = 0; i < W; i++) begin
      brev[i] = x[W-1-i];
    end
  end

  always_comb begin
    case (op)
      bmu_pkg::OP_SHR:     res = x >> amt;
      bmu_pkg::OP_HIGHBIT: res = smear & ~(smear >> 1);
      bmu_pkg::OP_LOWBIT:  res = x & (~x + W'(1));
      bmu_pkg::OP_POPCNT,
      bmu_pkg::OP_CLZ,
      bmu_pkg::OP_CTZ:     res = W'(pop_cnt);
      bmu_pkg::OP_ROTL:    res = rot_l[2*W-1:W];
      bmu_pkg::OP_ROTR:    res = rot_r[W-1:0];
      bmu_pkg::OP_BSWAP:   res = bswap;
      bmu_pkg::OP_BITREV:  res = brev;
      bmu_pkg::OP_SIGNUM: begin
        if (x[W-1]) res = '1;
        else if (x != '0) res = W'(1);
        else res = '0;
      end
      default:             res = '0;
    endcase
  end

endmodule

// ===== hdl/bit_manipulation_unit_64.sv =====
// Top level of the 64-bit bit manipulation unit: input register, operation
// datapath, result register. Depends on bmu_pkg, bmu_alu and the defines header.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------
//   request  | start / busy         | req_type, operand, amount
//   result   | done (1-cycle strobe)| result
//
// A request passes the input register and then the result register before result is taken.
// One request can be accepted every cycle; busy is always low.
// The datapath depth is set by the smear / popcount tree between the registers.
// rst clears the valid flags only; the receiver cannot stall.
`include "bit_manipulation_unit_64_defines.svh"

module bit_manipulation_unit_64 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [bmu_pkg::OP_W-1:0]          req_type,
  input  logic signed [bmu_pkg::DATA_W-1:0] operand,
  input  logic [bmu_pkg::AMT_W-1:0]         amount,
  output logic                              done,
  output logic signed [bmu_pkg::DATA_W-1:0] result
);

  logic                          in_vld;
  bmu_pkg::op_t                  in_op;
  logic [bmu_pkg::DATA_W-1:0]    in_x;
  logic [bmu_pkg::AMT_W-1:0]     in_amt;
  logic [bmu_pkg::DATA_W-1:0]    res_next;
  logic                          out_vld;
  bmu_pkg::op_t                  out_op;
  logic [bmu_pkg::DATA_W-1:0]    out_res;
  logic                          out_is_cnt;
  logic                          out_is_sgn;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      in_vld  <= start && !busy;
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    in_op   <= bmu_pkg::op_t'(req_type);
    in_x    <= operand;
    in_amt  <= amount;
    out_op  <= in_op;
    out_res <= res_next;
  end

  bmu_alu u_alu (
    .op  (in_op),
    .x   (in_x),
    .amt (in_amt),
    .res (res_next)
  );

  assign done   = out_vld;
  assign result = out_res;

  assign out_is_cnt = (out_op == bmu_pkg::OP_POPCNT) || (out_op == bmu_pkg::OP_CLZ) ||
                      (out_op == bmu_pkg::OP_CTZ);
  assign out_is_sgn = (out_op == bmu_pkg::OP_SIGNUM);

  `BMU_ASSERT_LAT2(a_latency, start && !busy, done)
  `BMU_ASSERT_IMPL(a_no_spurious, done, $past(start, 2))
  `BMU_ASSERT_IMPL(a_count_range, done && out_is_cnt, !result[63] && result <= 64'sd64)
  `BMU_ASSERT_IMPL(a_signum_range, done && out_is_sgn, result == 64'sd0 || result == 64'sd1 || result == -64'sd1)

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for bit_manipulation_unit_64: directed and random operations,
// a behavioral predictor per operation and an in-order result scoreboard.
// Depends on bmu_pkg and the bit_manipulation_unit_64 RTL.
module tb_top;

  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 1500;
  localparam int MAX_GAP    = 13;
  localparam int TAIL_CYC   = 8;
  localparam int DATA_W     = bmu_pkg::DATA_W;
  localparam int AMT_W      = bmu_pkg::AMT_W;
  localparam int OP_W       = bmu_pkg::OP_W;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] x;
    logic [AMT_W-1:0]  amt;
    int                gap;
    bit                drain;
  } bmu_req_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] x;
    logic [AMT_W-1:0]  amt;
    logic [DATA_W-1:0] value;
  } bmu_want_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic [OP_W-1:0]          req_type = '0;
  logic signed [DATA_W-1:0] operand = '0;
  logic [AMT_W-1:0]         amount = '0;
  logic                     done;
  logic signed [DATA_W-1:0] result;

  bmu_req_t  op_req_q[$];
  bmu_want_t awaited_q[$];
  int        idle_max = MAX_GAP;
  int        total_reqs = 0;
  int        accepted_cnt = 0;
  int        idle_cycles = 0;
  int        err_count = 0;
  bit        req_taken = 1'b0;
  bit        all_drained = 1'b0;

  bit_manipulation_unit_64 uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .operand  (operand),
    .amount   (amount),
    .done     (done),
    .result   (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] bit_op_result(logic [OP_W-1:0] op,
      logic [DATA_W-1:0] x, logic [AMT_W-1:0] amt);
    logic [2*DATA_W-1:0] dbl;
    logic [DATA_W-1:0]   r;
    int                  n;
    int                  i;
    r   = '0;
    n   = 0;
    dbl = {x, x};
    case (op)
      bmu_pkg::OP_SHR:     r = x >> amt;
      bmu_pkg::OP_HIGHBIT: begin
        for (i = 0; i < DATA_W; i++) if (x[i]) r = 64'd1 << i;
      end
      bmu_pkg::OP_LOWBIT:  r = x & (~x + 64'd1);
      bmu_pkg::OP_POPCNT: begin
        for (i = 0; i < DATA_W; i++) if (x[i]) n++;
        r = DATA_W'(n);
      end
      bmu_pkg::OP_CLZ: begin
        n = DATA_W;
        for (i = 0; i < DATA_W; i++) if (x[i]) n = DATA_W - 1 - i;
        r = DATA_W'(n);
      end
      bmu_pkg::OP_CTZ: begin
        n = DATA_W;
        for (i = DATA_W - 1; i >= 0; i--) if (x[i]) n = i;
        r = DATA_W'(n);
      end
      // doubled word makes a zero distance fall out naturally
      bmu_pkg::OP_ROTL: begin
        dbl = dbl << amt;
        r = dbl[2*DATA_W-1:DATA_W];
      end
      bmu_pkg::OP_ROTR: begin
        dbl = dbl >> amt;
        r = dbl[DATA_W-1:0];
      end
      bmu_pkg::OP_BSWAP: begin
        for (i = 0; i < 8; i++) r[8*i +: 8] = x[8*(7-i) +: 8];
      end
      bmu_pkg::OP_BITREV: begin
        for (i = 0; i < DATA_W; i++) r[i] = x[DATA_W-1-i];
      end
      bmu_pkg::OP_SIGNUM:  r = x[DATA_W-1] ? '1 : ((x != '0) ? 64'd1 : 64'd0);
      default:             r = '0;
    endcase
    return r;
  endfunction

  task automatic add_req(logic [OP_W-1:0] op, logic [DATA_W-1:0] x,
      logic [AMT_W-1:0] amt, bit drain);
    bmu_req_t q;
    q.op    = op;
    q.x     = x;
    q.amt   = amt;
    q.gap   = $urandom_range(0, idle_max);
    q.drain = drain;
    op_req_q.push_back(q);
  endtask

  task automatic report_mismatch(string what, bmu_want_t w, logic [DATA_W-1:0] got);
    $display("MISMATCH %s: op=%0d x=%h amt=%0d got=%h want=%h",
             what, w.op, w.x, w.amt, got, w.value);
    err_count++;
  endtask

  // Driver: a held start stays up until the transfer is seen at a rising edge.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !req_taken)) begin
      if (op_req_q.size() == 0) begin
        start <= 1'b0;
      end else if (op_req_q[0].gap > 0) begin
        op_req_q[0].gap = op_req_q[0].gap - 1;
        start <= 1'b0;
      end else if (op_req_q[0].drain && awaited_q.size() != 0) begin
        start <= 1'b0;
      end else begin
        req_type <= op_req_q[0].op;
        operand  <= op_req_q[0].x;
        amount   <= op_req_q[0].amt;
        start    <= 1'b1;
        void'(op_req_q.pop_front());
      end
    end
  end

  // Monitor and scoreboard
  always @(posedge clk) begin
    bmu_want_t w;
    req_taken = 1'b0;
    if (!rst) begin
      req_taken = start && !busy;
      if (req_taken) begin
        w.op    = req_type;
        w.x     = operand;
        w.amt   = amount;
        w.value = bit_op_result(req_type, operand, amount);
        awaited_q.push_back(w);
        accepted_cnt++;
      end
      if (done) begin
        if (awaited_q.size() == 0) begin
          w = '{op: '0, x: '0, amt: '0, value: '0};
          report_mismatch("result with nothing pending", w, result);
        end else begin
          w = awaited_q.pop_front();
          if (result !== w.value) report_mismatch("result", w, result);
        end
      end
      all_drained = (accepted_cnt == total_reqs) && (awaited_q.size() == 0);
      if (req_taken || done) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] x;
    logic [AMT_W-1:0]  amt;
    int                k;

    // directed: field extremes, every operation, corner operands
    add_req(bmu_pkg::OP_SHR,     64'h8000_0000_0000_0000, 6'd0,  1'b0);
    add_req(bmu_pkg::OP_SHR,     '1,                      6'd63, 1'b0);
    add_req(bmu_pkg::OP_SHR,     64'h0123_4567_89ab_cdef, 6'd17, 1'b0);
    add_req(bmu_pkg::OP_HIGHBIT, '0,                      6'd5,  1'b0);
    add_req(bmu_pkg::OP_HIGHBIT, 64'h8000_0000_0000_0000, 6'd0,  1'b0);
    add_req(bmu_pkg::OP_HIGHBIT, 64'd1,                   6'd63, 1'b0);
    add_req(bmu_pkg::OP_LOWBIT,  '0,                      6'd0,  1'b0);
    add_req(bmu_pkg::OP_LOWBIT,  64'h8000_0000_0000_0000, 6'd9,  1'b0);
    add_req(bmu_pkg::OP_POPCNT,  '1,                      6'd0,  1'b0);
    add_req(bmu_pkg::OP_POPCNT,  '0,                      6'd63, 1'b0);
    add_req(bmu_pkg::OP_CLZ,     '0,                      6'd0,  1'b0);
    add_req(bmu_pkg::OP_CLZ,     64'd1,                   6'd0,  1'b0);
    add_req(bmu_pkg::OP_CLZ,     '1,                      6'd33, 1'b0);
    add_req(bmu_pkg::OP_CTZ,     '0,                      6'd0,  1'b0);
    add_req(bmu_pkg::OP_CTZ,     64'h8000_0000_0000_0000, 6'd0,  1'b0);
    add_req(bmu_pkg::OP_ROTL,    64'hf00d_0000_1234_5678, 6'd0,  1'b0);
    add_req(bmu_pkg::OP_ROTL,    64'h8000_0000_0000_0001, 6'd63, 1'b0);
    add_req(bmu_pkg::OP_ROTR,    64'hf00d_0000_1234_5678, 6'd0,  1'b0);
    add_req(bmu_pkg::OP_ROTR,    64'h0000_0000_0000_0003, 6'd1,  1'b0);
    add_req(bmu_pkg::OP_BSWAP,   64'h0102_0304_0506_0708, 6'd0,  1'b0);
    add_req(bmu_pkg::OP_BITREV,  64'h0000_0000_0000_00f1, 6'd63, 1'b0);
    add_req(bmu_pkg::OP_SIGNUM,  64'h8000_0000_0000_0000, 6'd0,  1'b0);
    add_req(bmu_pkg::OP_SIGNUM,  64'h7fff_ffff_ffff_ffff, 6'd0,  1'b0);
    add_req(bmu_pkg::OP_SIGNUM,  '0,                      6'd0,  1'b0);
    add_req(4'd11,               '1,                      6'd7,  1'b0);
    add_req(4'd15,               64'h7fff_ffff_ffff_ffff, 6'd63, 1'b0);

    for (k = 0; k < RAND_ITEMS; k++) begin
      // alternate stretches of back-to-back traffic and random gaps
      if (k % 100 == 0) idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      if ($urandom_range(0, 9) == 0) op = OP_W'($urandom_range(11, 15));
      else op = OP_W'($urandom_range(0, 10));
      case ($urandom_range(0, 7))
        0:       x = '0;
        1:       x = '1;
        2:       x = 64'd1 << $urandom_range(0, 63);
        3:       x = {$urandom, $urandom} >> $urandom_range(0, 63);
        4:       x = {$urandom, $urandom} << $urandom_range(0, 63);
        5:       x = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000
                                          : 64'h7fff_ffff_ffff_ffff;
        default: x = {$urandom, $urandom};
      endcase
      amt = AMT_W'($urandom_range(0, 63));
      add_req(op, x, amt, (k % 400 == 0));
    end
    total_reqs = op_req_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(negedge clk); while (!all_drained);
    repeat (TAIL_CYC) @(negedge clk);
    if (err_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
